>>> hw/rtl/chm_pkg.sv
`default_nettype none
package chm_pkg;
  localparam int NumBuckets = 16;
  localparam int NumNodes   = 64;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int BktW  = $clog2(NumBuckets);
  localparam int NodeW = $clog2(NumNodes);
  localparam int LinkW = $clog2(NumNodes + 1);
  localparam int CntW  = 7;
  localparam logic [LinkW-1:0] NullLink = LinkW'(NumNodes);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_PUT = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic        full_res;
    logic [6:0]  entry_count;
  } out_item_t;

  // Classified item passed from front to back.
  typedef struct packed {
    cmd_e              cmd;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [BktW-1:0]      bkt;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_READ,
    ST_CMP,
    ST_UPD,
    ST_DONE
  } bk_state_e;
endpackage
`default_nettype wire

>>> hw/rtl/chained_hash_map_engine.sv
`default_nettype none
// Separate-chaining hash map: 16 buckets (key mod 16) over a 64-node pool.
// Raise start with cmd/key/value while busy is low; busy then stays high
// up to and including the result strobe cycle, so no new item is accepted
// before the previous result. An accepted item is queued, popped in IDLE,
// then passes HEAD, a READ and a CMP state per chain node visited (none for
// an empty bucket or a nop), then UPD and DONE, which raises the strobe.
// Results appear on out_* for exactly
// one cycle with out_valid high; the receiver cannot stall. put returns the
// old value or appends at the tail (full_res when no free node is left), get
// returns the value, delete unlinks and frees. Node contents need no
// clearing pass: links not yet written read as the reset free list.
module chained_hash_map_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire chm_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output chm_pkg::out_item_t       out_item
);
  import chm_pkg::*;

  logic  q_valid, q_pop, back_busy;
  work_t q_data;

  chm_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .q_valid, .q_data, .q_pop, .back_busy
  );

  chm_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop, .back_busy,
    .out_valid, .out_item
  );
endmodule
`default_nettype wire

>>> hw/rtl/chm_front.sv
`default_nettype none
module chm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire chm_pkg::in_item_t in_item,
  output logic                  q_valid,
  output chm_pkg::work_t        q_data,
  input  wire logic             q_pop,
  input  wire logic             back_busy
);
  import chm_pkg::*;

  work_t            q_r [QDepth];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  work_t            w;

  // Only one item is in the block at a time; queue decouples timing.
  assign busy    = (cnt_r != 2'd0) || back_busy;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_r[0];

  always_comb begin
    w.cmd   = cmd_e'(in_item.cmd);
    w.key   = in_item.key[KeyBits-1:0];
    w.value = in_item.value[ValueBits-1:0];
    w.bkt   = in_item.key[BktW-1:0];
  end

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) q_r[0] <= q_r[1];
    if (push) begin
      if (q_pop && cnt_r == 2'd1) q_r[0] <= w;
      else if (cnt_r == 2'd0) q_r[0] <= w;
      else q_r[1] <= w;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> busy) else $error("busy not raised after accept");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/chm_back.sv
`default_nettype none
module chm_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire chm_pkg::work_t     q_data,
  output logic                    q_pop,
  output logic                    back_busy,
  output logic                    out_valid,
  output chm_pkg::out_item_t      out_item
);
  import chm_pkg::*;

  logic [LinkW-1:0]     head_r [NumBuckets];
  logic [KeyBits-1:0]   nkey_m [NumNodes];
  logic [ValueBits-1:0] nval_m [NumNodes];
  logic [LinkW-1:0]     nlnk_m [NumNodes];
  logic [NumNodes-1:0]  lnk_wr_r;   // link written since reset
  logic [LinkW-1:0]     free_r;
  logic [CntW-1:0]      count_r;

  bk_state_e st_r, st_nxt;
  work_t     w_r;
  logic [LinkW-1:0] cur_r, prev_r;
  logic [NodeW:0]   steps_r;
  logic [KeyBits-1:0]   rd_key_r;
  logic [ValueBits-1:0] rd_val_r;
  logic [LinkW-1:0]     rd_lnk_r;
  logic [LinkW-1:0]     rd_lnk_v;
  logic [NodeW-1:0]     cur_idx;
  logic hit;
  out_item_t res_r;
  logic      ov_r;

  assign cur_idx = cur_r[NodeW-1:0];
  assign q_pop   = (st_r == ST_IDLE) && q_valid;
  assign back_busy = (st_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_item  = res_r;
  assign hit = (rd_key_r == w_r.key);
  // Unwritten link reads as its free-list reset value.
  assign rd_lnk_v = rd_lnk_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_HEAD;
      ST_HEAD: st_nxt = (w_r.cmd == CMD_NOP || head_r[w_r.bkt] == NullLink) ? ST_UPD : ST_READ;
      ST_READ: st_nxt = ST_CMP;
      ST_CMP: begin
        if (hit || rd_lnk_v == NullLink || steps_r == (NodeW+1)'(NumNodes-1))
          st_nxt = ST_UPD;
        else
          st_nxt = ST_READ;
      end
      ST_UPD:  st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  logic found_r;
  logic [LinkW-1:0] fl_nxt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumBuckets; i++) head_r[i] <= NullLink;
      lnk_wr_r <= '0;
      free_r   <= '0;
      count_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          w_r <= q_data;
          found_r <= 1'b0;
        end
        ST_HEAD: begin
          cur_r   <= head_r[w_r.bkt];
          prev_r  <= NullLink;
          steps_r <= '0;
        end
        ST_READ: begin
          rd_key_r <= nkey_m[cur_idx];
          rd_val_r <= nval_m[cur_idx];
          rd_lnk_r <= lnk_wr_r[cur_idx] ? nlnk_m[cur_idx] : LinkW'(cur_r + 1'b1);
        end
        ST_CMP: begin
          if (hit) found_r <= 1'b1;
          else begin
            prev_r  <= cur_r;
            cur_r   <= rd_lnk_v;
            steps_r <= steps_r + 1'b1;
          end
        end
        ST_UPD: begin
          res_r.found     <= found_r && w_r.cmd != CMD_NOP;
          res_r.value_out <= (found_r && w_r.cmd != CMD_NOP) ? rd_val_r : '0;
          res_r.full_res  <= 1'b0;
          if (free_r != NullLink) begin
            fl_nxt_r <= lnk_wr_r[free_r[NodeW-1:0]] ? nlnk_m[free_r[NodeW-1:0]]
                                                   : LinkW'(free_r + 1'b1);
          end else fl_nxt_r <= NullLink;
        end
        ST_DONE: begin
          ov_r <= 1'b1;
          if (w_r.cmd == CMD_PUT) begin
            if (found_r) begin
              nval_m[cur_idx] <= w_r.value;
              res_r.entry_count <= count_r;
            end else if (free_r == NullLink) begin
              res_r.full_res <= 1'b1;
              res_r.entry_count <= count_r;
            end else begin
              nkey_m[free_r[NodeW-1:0]] <= w_r.key;
              nval_m[free_r[NodeW-1:0]] <= w_r.value;
              nlnk_m[free_r[NodeW-1:0]] <= NullLink;
              lnk_wr_r[free_r[NodeW-1:0]] <= 1'b1;
              if (prev_r != NullLink) begin
                nlnk_m[prev_r[NodeW-1:0]]   <= free_r;
                lnk_wr_r[prev_r[NodeW-1:0]] <= 1'b1;
              end else head_r[w_r.bkt] <= free_r;
              free_r  <= fl_nxt_r;
              count_r <= count_r + 1'b1;
              res_r.entry_count <= count_r + 1'b1;
            end
          end else if (w_r.cmd == CMD_DEL && found_r) begin
            if (prev_r != NullLink) begin
              nlnk_m[prev_r[NodeW-1:0]]   <= rd_lnk_v;
              lnk_wr_r[prev_r[NodeW-1:0]] <= 1'b1;
            end else head_r[w_r.bkt] <= rd_lnk_v;
            nlnk_m[cur_idx]   <= free_r;
            lnk_wr_r[cur_idx] <= 1'b1;
            free_r <= cur_r;
            if (count_r != '0) begin
              count_r <= count_r - 1'b1;
              res_r.entry_count <= count_r - 1'b1;
            end else begin
              res_r.entry_count <= count_r;
            end
          end else begin
            res_r.entry_count <= count_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("double result strobe");
  a_full_put: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && res_r.full_res |-> w_r.cmd == CMD_PUT && !res_r.found)
    else $error("full flagged wrongly");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(NumNodes)) else $error("count beyond pool");
`endif
endmodule
`default_nettype wire

>>> dv/chm_checker.sv
`timescale 1ns / 100ps
module chm_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire chm_pkg::in_item_t  in_item,
  input  wire logic               out_valid,
  input  wire chm_pkg::out_item_t out_item,
  output int                      err_count,
  output int                      pending
);
  import chm_pkg::*;

  localparam logic [6:0] NIL = 7'(NumNodes);

  logic [6:0]  head_q [NumBuckets];
  logic [31:0] key_q  [NumNodes];
  logic [31:0] val_q  [NumNodes];
  logic [6:0]  link_q [NumNodes];
  logic [6:0]  free_q;
  logic [6:0]  count_q;
  out_item_t   expected_q [$];

  // Apply one command to the shadow table and return the expected reply.
  function automatic out_item_t map_apply(in_item_t it);
    out_item_t   r;
    logic [6:0]  cur, back, n;
    logic [3:0]  b;
    int          steps;
    r = '0;
    b = it.key[3:0];
    cur = head_q[b];
    back = NIL;
    steps = 0;
    if (it.cmd != CMD_NOP) begin
      while (cur != NIL && steps < NumNodes) begin
        if (key_q[cur] == it.key) break;
        back = cur;
        cur = link_q[cur];
        steps++;
      end
      if (cur != NIL) begin
        r.found = 1'b1;
        r.value_out = val_q[cur];
      end
      if (it.cmd == CMD_PUT) begin
        if (cur != NIL) begin
          val_q[cur] = it.value;
        end else if (free_q == NIL) begin
          r.full_res = 1'b1;
        end else begin
          n = free_q;
          free_q = link_q[n];
          key_q[n] = it.key;
          val_q[n] = it.value;
          link_q[n] = NIL;
          if (back != NIL) link_q[back] = n;
          else head_q[b] = n;
          count_q++;
        end
      end else if (it.cmd == CMD_DEL && cur != NIL) begin
        if (back != NIL) link_q[back] = link_q[cur];
        else head_q[b] = link_q[cur];
        link_q[cur] = free_q;
        free_q = cur;
        if (count_q != 0) count_q--;
      end
    end
    r.entry_count = count_q;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < NumBuckets; i++) head_q[i] = NIL;
      for (int i = 0; i < NumNodes; i++) begin
        key_q[i] = '0;
        val_q[i] = '0;
        link_q[i] = 7'(i + 1);
      end
      free_q = '0;
      count_q = '0;
      expected_q.delete();
      err_count <= 0;
    end else begin
      // result checked before the new item, as at most one is in flight
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          err_count <= err_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_item) begin
            $display("%0t: mismatch expected f=%b v=%h full=%b cnt=%0d,",
                     $time, e.found, e.value_out, e.full_res, e.entry_count);
            $display("%0t:   actual f=%b v=%h full=%b cnt=%0d",
                     $time, out_item.found, out_item.value_out,
                     out_item.full_res, out_item.entry_count);
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(map_apply(in_item));
    end
  end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import chm_pkg::*;

  localparam int RandItems = 1850;
  localparam int StallLimit = 2000; // idle cycles with nothing accepted

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        err_count;
  int        pending;
  int        idle_cycles = 0;

  // recent keys reused so that chains grow and hits are common
  logic [31:0] key_pool [$];

  always #5 clk = ~clk;

  chained_hash_map_engine u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  chm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item),
    .err_count(err_count), .pending(pending)
  );

  // watchdog: no item and no result accepted for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Present one item at the falling edge, hold until accepted.
  task automatic send_item(cmd_e c, logic [31:0] k, logic [31:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_item <= '{cmd: c, key: k, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    case ($urandom_range(0, 3))
      0: k = $urandom();
      1: k = 32'({3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))});
      2: k = {28'hfffffff, 4'($urandom_range(0, 15))};
      default: k = {28'($urandom_range(0, 3)), 4'($urandom_range(0, 1))};
    endcase
    key_pool.push_back(k);
    if (key_pool.size() > 96) void'(key_pool.pop_front());
    return k;
  endfunction

  initial begin
    int burst;
    int mode;
    cmd_e c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, misses, replace, unused command
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_DEL, 32'hffffffff, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'hffffffff);
    send_item(CMD_PUT, 32'hffffffff, 32'h0);
    send_item(CMD_PUT, 32'h10, 32'h5a5a5a5a);
    send_item(CMD_PUT, 32'h20, 32'ha5a5a5a5);
    send_item(CMD_PUT, 32'h10, 32'h12345678);     // replace mid-chain
    send_item(CMD_GET, 32'h20, 32'hffffffff);
    send_item(CMD_GET, 32'h30, 32'h0);            // miss on populated chain
    send_item(CMD_NOP, 32'h10, 32'hdeadbeef);
    send_item(CMD_DEL, 32'h10, 32'h0);            // unlink middle node
    send_item(CMD_GET, 32'h20, 32'h0);
    send_item(CMD_DEL, 32'h0, 32'h0);             // unlink head
    send_item(CMD_GET, 32'hffffffff, 32'h0);
    send_item(CMD_DEL, 32'h0, 32'h0);             // delete miss
    send_item(CMD_PUT, 32'h40, 32'h1);            // reuses freed node
    pause(3);

    // random: phases alternating fill-heavy and drain-heavy so the pool runs dry
    for (int n = 0; n < RandItems; ) begin
      mode = (n / 300) % 2;
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: c = (mode == 0) ? CMD_PUT : CMD_DEL;
          4, 5: c = CMD_PUT;
          6, 7: c = CMD_GET;
          8: c = CMD_DEL;
          default: c = ($urandom_range(0, 3) == 0) ? CMD_NOP : CMD_GET;
        endcase
        send_item(c, pick_key(), $urandom());
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
